// ===== rtl/core/sha256_pkg.sv =====
// SHA-256 stream hasher: shared types, constants and round functions.
// No dependencies; used by every module in rtl/core.
`default_nettype none
package sha256_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Request passed from the front end to the compression engine
    typedef struct packed {
        logic [31:0] word;       // block word, big-endian
        logic [3:0]  widx;       // position in block
        logic        finish;     // emit digest after this block
    } blk_word_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned LEN_FILL = 56;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] r;
        begin
            case (i)
                3'd0: r = 32'h6a09e667;
                3'd1: r = 32'hbb67ae85;
                3'd2: r = 32'h3c6ef372;
                3'd3: r = 32'ha54ff53a;
                3'd4: r = 32'h510e527f;
                3'd5: r = 32'h9b05688c;
                3'd6: r = 32'h1f83d9ab;
                default: r = 32'h5be0cd19;
            endcase
            return r;
        end
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        begin
            return (x >> n) | (x << (32 - n));
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha256_stream_hasher.sv =====
// SHA-256 stream hasher top level: front end, request queue, compression engine.
// Depends on sha256_pkg, sha256_front, sha256_fifo, sha256_core.
//
// Usage: stream message words on in_data (valid/ready), big-endian, with
// byte_count valid leading bytes; only the end_of_message word may be short.
// An empty message is a single zero-byte word with end_of_message set.
// Each request with end_of_message yields eight digest words on out_data
// (valid/ready), word_index 0..7, last_word on the eighth.
// Each 64-byte block is loaded as 16 words, then the compression engine runs
// 64 rounds and adds the result into the chain value; the single round unit
// limits throughput, and the engine takes no words of the next block until then.
// After the final word, the first digest word waits for one or two blocks to
// be compressed (padding may need an extra block) and for the queue.
// The four-entry queue lets the front end keep accepting words during rounds.
// Reset restores the initial hash values and clears the length and fill.
// If the receiver stalls, the digest holds and the engine accepts no new
// block until all eight words are taken; the front end backs up via the queue.
`default_nettype none
module sha256_stream_hasher (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sha256_pkg::in_item_t  in_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output sha256_pkg::out_item_t      out_data,
    output logic                       out_valid,
    input  wire logic                  out_ready
);
    import sha256_pkg::*;

    blk_word_t f_data, c_data;
    logic      f_valid, f_ready, c_valid, c_ready;

    sha256_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
        .wq_data(f_data), .wq_valid(f_valid), .wq_ready(f_ready)
    );

    sha256_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_data(f_data), .wr_valid(f_valid), .wr_ready(f_ready),
        .rd_data(c_data), .rd_valid(c_valid), .rd_ready(c_ready)
    );

    sha256_core u_core (
        .clk(clk), .rst_n(rst_n),
        .wq_data(c_data), .wq_valid(c_valid), .wq_ready(c_ready),
        .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
    );
endmodule
`default_nettype wire

// ===== rtl/core/sha256_front.sv =====
// SHA-256 front end: packs message bytes into block words, adds padding and length.
// Depends on sha256_pkg.
`default_nettype none
module sha256_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sha256_pkg::in_item_t in_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output sha256_pkg::blk_word_t     wq_data,
    output logic                      wq_valid,
    input  wire logic                 wq_ready
);
    import sha256_pkg::*;

    typedef enum logic [3:0] {
        S_IN  = 4'b0001,
        S_PAD = 4'b0010,
        S_LEN = 4'b0100,
        S_LO  = 4'b1000
    } fstate_t;

    fstate_t     state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;          // bytes in current block
    logic [31:0] part_reg, part_next;          // partially built word
    logic [63:0] bits_reg, bits_next;
    logic        padded_reg, padded_next;       // 0x80 already placed

    logic [2:0]  cnt;
    logic [1:0]  off;
    logic [31:0] din;                           // valid leading bytes only
    logic [63:0] word_sh;
    logic [31:0] merged;
    logic [2:0]  new_off;
    logic        emit;

    assign cnt = (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
    assign off = fill_reg[1:0];
    assign din = in_data.data_word & ~(32'hffffffff >> ({3'd0, cnt} * 6'd8));

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        part_next   = part_reg;
        bits_next   = bits_reg;
        padded_next = padded_reg;
        in_ready    = 1'b0;
        wq_valid    = 1'b0;
        wq_data     = '0;
        word_sh     = '0;
        merged      = part_reg;
        new_off     = {1'b0, off};
        emit        = 1'b0;
        case (state_reg)
            S_IN:
            begin
                // merge new bytes; word completes when offset wraps
                word_sh = {din, 32'h0} >> ({3'd0, off} * 6'd8);
                merged  = part_reg | word_sh[63:32];
                new_off = {1'b0, off} + cnt;
                emit    = new_off[2];
                wq_data.word   = merged;
                wq_data.widx   = fill_reg[5:2];
                wq_data.finish = 1'b0;
                wq_valid = in_valid && emit;
                in_ready = !emit || wq_ready;
                if (in_valid && in_ready)
                begin
                    bits_next = bits_reg + {58'd0, cnt, 3'd0};
                    fill_next = fill_reg + {3'd0, cnt};
                    if (emit)
                        part_next = word_sh[31:0];
                    else
                        part_next = merged & ~(32'hffffffff >> ({3'd0, new_off[1:0]} * 6'd8));
                    if (new_off[1:0] == 2'd0 && !emit)
                        part_next = '0;
                    if (in_data.end_of_message)
                        state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                // place 0x80 then zero words until the length slot
                merged = padded_reg ? part_reg
                       : part_reg | ({PAD_BYTE, 24'h0} >> ({3'd0, off} * 6'd8));
                wq_data.word   = merged;
                wq_data.widx   = fill_reg[5:2];
                wq_data.finish = 1'b0;
                wq_valid = 1'b1;
                if (wq_ready)
                begin
                    padded_next = 1'b1;
                    part_next   = '0;
                    fill_next   = {fill_reg[5:2] + 4'd1, 2'b00};
                    if (fill_reg[5:2] + 4'd1 == 4'(LEN_FILL / 4))
                        state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                wq_data.word   = bits_reg[63:32];
                wq_data.widx   = 4'd14;
                wq_data.finish = 1'b0;
                wq_valid = 1'b1;
                if (wq_ready)
                    state_next = S_LO;
            end
            default:
            begin
                wq_data.word   = bits_reg[31:0];
                wq_data.widx   = 4'd15;
                wq_data.finish = 1'b1;
                wq_valid = 1'b1;
                if (wq_ready)
                begin
                    state_next  = S_IN;
                    fill_next   = '0;
                    part_next   = '0;
                    bits_next   = '0;
                    padded_next = 1'b0;
                end
            end
        endcase
    end

    // hold front-end state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IN;
            fill_reg   <= '0;
            part_reg   <= '0;
            bits_reg   <= '0;
            padded_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            part_reg   <= part_next;
            bits_reg   <= bits_next;
            padded_reg <= padded_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/sha256_fifo.sv =====
// Short request queue between front end and compression engine.
// Depends on sha256_pkg.
`default_nettype none
module sha256_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sha256_pkg::blk_word_t wr_data,
    input  wire logic                  wr_valid,
    output logic                       wr_ready,
    output sha256_pkg::blk_word_t      rd_data,
    output logic                       rd_valid,
    input  wire logic                  rd_ready
);
    import sha256_pkg::*;

    blk_word_t  mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       wr_en, rd_en;

    assign wr_ready = cnt_reg != 3'd4;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    // store requests
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 2'd1;
            if (rd_en)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, wr_en} - {2'd0, rd_en};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/sha256_core.sv =====
// SHA-256 compression engine: gathers 16 words, runs 64 rounds, emits digest after a finishing block.
// Depends on sha256_pkg.
`default_nettype none
module sha256_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sha256_pkg::blk_word_t wq_data,
    input  wire logic                  wq_valid,
    output logic                       wq_ready,
    output sha256_pkg::out_item_t      out_data,
    output logic                       out_valid,
    input  wire logic                  out_ready
);
    import sha256_pkg::*;

    typedef enum logic [3:0] {
        C_LOAD  = 4'b0001,
        C_ROUND = 4'b0010,
        C_ADD   = 4'b0100,
        C_OUT   = 4'b1000
    } cstate_t;

    cstate_t     state_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  rnd_reg;
    logic [2:0]  oidx_reg;
    logic        fin_reg;

    logic [31:0] w_new, w_cur, s0, s1, ch, mj, t1, t2, g0, g1;

    assign wq_ready = state_reg == C_LOAD;

    // schedule: w_reg[0] is the current word, shifts every round
    always_comb
    begin
        g0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        g1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + g0 + w_reg[9] + g1;
        w_cur = w_reg[0];
        s1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + s1 + ch + ROUND_K[rnd_reg] + w_cur;
        s0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = s0 + mj;
    end

    assign out_valid            = state_reg == C_OUT;
    assign out_data.digest_word = h_reg[oidx_reg];
    assign out_data.word_index  = oidx_reg;
    assign out_data.last_word   = oidx_reg == 3'd7;

    // data path
    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_LOAD:
            begin
                if (wq_valid)
                begin
                    w_reg[wq_data.widx] <= wq_data.word;
                    fin_reg <= wq_data.finish;
                    for (int i = 0; i < 8; i++)
                        v_reg[i] <= h_reg[i];
                end
            end
            C_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i + 1];
                w_reg[15] <= w_new;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            default:
            begin
            end
        endcase
    end

    // control and chain value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_LOAD;
            rnd_reg   <= '0;
            oidx_reg  <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_hash(3'(i));
        end
        else
        begin
            case (state_reg)
                C_LOAD:
                begin
                    if (wq_valid && wq_data.widx == 4'd15)
                    begin
                        state_reg <= C_ROUND;
                        rnd_reg   <= '0;
                    end
                end
                C_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                        state_reg <= C_ADD;
                end
                C_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    state_reg <= fin_reg ? C_OUT : C_LOAD;
                    oidx_reg  <= '0;
                end
                default:
                begin
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            state_reg <= C_LOAD;
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= init_hash(3'(i));
                        end
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for sha256_stream_hasher: streams messages, predicts each digest
// in SystemVerilog and checks every digest word. Depends on sha256_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
    import sha256_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned N_DIR = 10;

    typedef struct {
        logic [31:0] d;
        logic [2:0]  c;
        logic        e;
        int unsigned reps;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    in_item_t    in_data;
    logic        in_valid;
    logic        in_ready;
    out_item_t   out_data;
    logic        out_valid;
    logic        out_ready;

    sha256_stream_hasher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    // Round constants for the predictor
    logic [31:0] kconst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    logic [31:0] iv [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Directed rows: data, byte count, end flag, repeat count
    dir_row_t dir_tab [N_DIR] = '{
        '{32'h00000000, 3'd0, 1'b1, 1},    // empty message
        '{32'h61626300, 3'd3, 1'b1, 1},    // "abc"
        '{32'hFFFFFFFF, 3'd7, 1'b0, 1},    // count above four
        '{32'h12345678, 3'd0, 1'b0, 1},    // zero bytes, not final
        '{32'hA5A5A5A5, 3'd1, 1'b0, 1},    // short word, not final
        '{32'h00000000, 3'd4, 1'b1, 1},
        '{32'h5A5A5A5A, 3'd4, 1'b0, 13},   // 55 bytes: padding fits
        '{32'hC3C3C3C3, 3'd3, 1'b1, 1},
        '{32'hFFFFFFFF, 3'd4, 1'b0, 14},   // 56 bytes: extra block
        '{32'h00000000, 3'd0, 1'b1, 1}
    };
    // First digest word of the empty message and of "abc"
    logic [31:0] known_h0 [2] = '{32'he3b0c442, 32'hba7816bf};

    // Predictor state
    logic [31:0] hash_state [8];
    logic [31:0] blk_words [16];
    logic [5:0]  fill_pos;
    logic [63:0] bit_len;

    out_item_t   digest_queue [$];
    in_item_t    request_queue [$];
    int unsigned errors;
    int unsigned digests_seen;
    int unsigned words_sent;
    int unsigned idle_cycles;
    bit          feed_done;
    bit          hold_off;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] v [8];
        logic [31:0] w, a15, a2, t1, t2;
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                w = blk_words[t];
            else
            begin
                a15 = blk_words[(t + 1) & 15];
                a2  = blk_words[(t + 14) & 15];
                w = blk_words[t & 15] + (ror(a15, 7) ^ ror(a15, 18) ^ (a15 >> 3))
                    + blk_words[(t + 9) & 15] + (ror(a2, 17) ^ ror(a2, 19) ^ (a2 >> 10));
                blk_words[t & 15] = w;
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst[t] + w;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic append_byte(input logic [7:0] b);
        int sh;
        sh = 24 - 8 * fill_pos[1:0];
        blk_words[fill_pos[5:2]] = (blk_words[fill_pos[5:2]] & ~(32'hFF << sh))
                                   | (32'(b) << sh);
        fill_pos = fill_pos + 6'd1;
        if (fill_pos == 6'd0)
            compress();
    endtask

    task automatic clear_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = iv[i];
        for (int i = 0; i < 16; i++) blk_words[i] = '0;
        fill_pos = '0;
        bit_len  = '0;
    endtask

    // Append a request to the stimulus queue
    task automatic enqueue_req(input in_item_t it);
        request_queue = {request_queue, it};
    endtask

    // Absorb one request; on the end flag queue the eight digest words
    task automatic absorb_word(input in_item_t it);
        int unsigned n;
        logic [63:0] len;
        out_item_t o;
        n = (it.byte_count > 3'd4) ? 4 : it.byte_count;
        for (int i = 0; i < n; i++)
        begin
            append_byte(it.data_word[31 - 8 * i -: 8]);
            bit_len += 64'd8;
        end
        if (it.end_of_message)
        begin
            len = bit_len;
            append_byte(PAD_BYTE);
            while (fill_pos != 6'(LEN_FILL)) append_byte(8'h00);
            for (int s = 56; s >= 0; s -= 8) append_byte(len[s +: 8]);
            for (int i = 0; i < 8; i++)
            begin
                o.digest_word = hash_state[i];
                o.word_index  = 3'(i);
                o.last_word   = (i == 7);
                digest_queue = {digest_queue, o};
            end
            clear_hash();
        end
    endtask

    function automatic in_item_t mk(input logic [31:0] d, input logic [2:0] c,
                                    input logic e);
        in_item_t r;
        r.data_word = d; r.byte_count = c; r.end_of_message = e;
        return r;
    endfunction

    // Queue a random message: mostly well formed, some odd short words
    task automatic queue_message();
        int unsigned len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 34) : $urandom_range(0, 15);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                enqueue_req(mk($urandom, 3'($urandom_range(0, 7)), 1'b0));
            else
                enqueue_req(mk($urandom, 3'd4, 1'b0));
        end
        enqueue_req(mk($urandom, 3'($urandom_range(0, 7)), 1'b1));
    endtask

    function automatic int unsigned gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
             : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
    endfunction

    always
    begin
        clk = 1'b1; #4;
        clk = 1'b0; #4;
    end

    // Sender: drive one request at a time with random gaps
    initial
    begin
        in_item_t cur;
        int unsigned gap;
        rst_n = 1'b0; in_valid = 1'b0; in_data = '0; feed_done = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gap = gap_len();
        while (request_queue.size() > 0)
        begin
            cur = request_queue.pop_front();
            repeat (gap) @(posedge clk);
            in_data  <= cur;
            in_valid <= 1'b1;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            absorb_word(cur);
            words_sent++;
            // drop valid only when a gap follows or nothing is left
            gap = gap_len();
            if (request_queue.size() == 0 || gap != 0)
                in_valid <= 1'b0;
        end
        feed_done = 1'b1;
    end

    // Receiver: random stalls plus one long hold-off early on
    initial
    begin
        out_ready = 1'b0;
        hold_off  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_off && words_sent >= 40)
            begin
                hold_off = 1'b1;
                out_ready <= 1'b0;
                repeat (2000) @(posedge clk);
            end
            out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 :
                         ($urandom_range(0, 3) != 0);
        end
    end

    // Check each accepted digest word against the oldest prediction
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (digest_queue.size() == 0)
            begin
                $error("unexpected digest word %h", out_data.digest_word);
                errors++;
            end
            else
            begin
                e = digest_queue.pop_front();
                if (out_data.digest_word !== e.digest_word)
                begin
                    $error("digest_word expected %h actual %h", e.digest_word,
                           out_data.digest_word);
                    errors++;
                end
                if (out_data.word_index !== e.word_index)
                begin
                    $error("word_index expected %0d actual %0d", e.word_index,
                           out_data.word_index);
                    errors++;
                end
                if (out_data.last_word !== e.last_word)
                begin
                    $error("last_word expected %0d actual %0d", e.last_word,
                           out_data.last_word);
                    errors++;
                end
                // the first two digests have a known leading word
                if (digests_seen < 2 && out_data.word_index == 3'd0 &&
                    out_data.digest_word !== known_h0[digests_seen])
                begin
                    $error("digest_word expected %h actual %h", known_h0[digests_seen],
                           out_data.digest_word);
                    errors++;
                end
                if (e.last_word) digests_seen++;
            end
        end
    end

    // Watchdog on cycles without any accepted request or digest word
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Directed table, then random messages
    initial
    begin
        errors = 0; digests_seen = 0; words_sent = 0; idle_cycles = 0;
        clear_hash();
        for (int r = 0; r < N_DIR; r++)
            for (int k = 0; k < dir_tab[r].reps; k++)
                enqueue_req(mk(dir_tab[r].d, dir_tab[r].c, dir_tab[r].e));
        while (request_queue.size() < 215) queue_message();

        wait (feed_done && digest_queue.size() == 0);
        repeat (400) @(posedge clk);
        $display("Sent %0d requests, checked %0d digests including empty, abc,",
                 words_sent, digests_seen);
        $display("padding-boundary and long messages, with a long output hold-off.");
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
